FILE: sv/hpt_pkg.sv
// Shared types and constants of the homogeneous point transform.
// No dependencies; every other file of the block imports this package.
package hpt_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 16;
    localparam int ROW_W     = 64;
    localparam int NUM_ROWS  = 4;
    localparam int NUM_COLS  = 4;
    localparam int NUM_LANES = 3;
    localparam int PROD_W    = COEF_W + COORD_W + 1;
    localparam int SUM_W     = 52;
    localparam int MAG_W     = SUM_W - 1;
    localparam int QUO_W     = 33;
    localparam int DIV_STEPS = QUO_W;
    localparam int PADDR_W   = 5;

    localparam logic signed [SUM_W-1:0] Q28_ONE = SUM_W'(64'sd268435456);
    localparam logic [QUO_W-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
    localparam logic [QUO_W-1:0] NEG_LIMIT = 33'h0_8000_0000;
    localparam logic [COORD_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] OUT_MIN = 32'h8000_0000;

    typedef enum logic [1:0]
    {
        REG_ROW_X = 2'd0,
        REG_ROW_Y = 2'd1,
        REG_ROW_Z = 2'd2,
        REG_ROW_W = 2'd3
    } reg_idx_t;

    localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_W_RESET = 64'h1000_0000_0000_0000;

    typedef logic [NUM_ROWS-1:0][ROW_W-1:0]   rows_t;
    typedef logic [NUM_ROWS-1:0][SUM_W-1:0]   sums_t;
    typedef logic [NUM_LANES-1:0][QUO_W-1:0]  quos_t;
    typedef logic [NUM_LANES-1:0][COORD_W-1:0] coords_t;

    // Per-point information that rides along the divider.
    typedef struct packed
    {
        logic [NUM_LANES-1:0] neg;
        logic [NUM_LANES-1:0] ovf;
        logic                 one;
        logic                 zero;
        coords_t              one_res;
        logic                 one_sat;
    } side_t;

endpackage

FILE: sv/hpt_regs.sv
// Configuration register file: four 64-bit matrix rows behind an APB-style port.
// Depends on hpt_pkg.
module hpt_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpt_pkg::PADDR_W-1:0]   paddr,
    input  logic [hpt_pkg::ROW_W-1:0]     pwdata,
    output logic [hpt_pkg::ROW_W-1:0]     prdata,
    output logic                          pready,
    output hpt_pkg::rows_t                rows
);
    import hpt_pkg::*;

    rows_t    rows_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
    assign pready = 1'b1;
    assign prdata = rows_reg[idx];
    assign rows   = rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg[REG_ROW_X] <= ROW_X_RESET;
            rows_reg[REG_ROW_Y] <= ROW_Y_RESET;
            rows_reg[REG_ROW_Z] <= ROW_Z_RESET;
            rows_reg[REG_ROW_W] <= ROW_W_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            rows_reg[idx] <= pwdata;
        end
    end

endmodule

FILE: sv/hpt_dot.sv
// Matrix-vector product: multiply stage, pair-sum stage and final-sum stage.
// Depends on hpt_pkg.
module hpt_dot
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [hpt_pkg::COORD_W-1:0]  x_in,
    input  logic [hpt_pkg::COORD_W-1:0]  y_in,
    input  logic [hpt_pkg::COORD_W-1:0]  z_in,
    input  hpt_pkg::rows_t               rows,
    output logic                         out_valid,
    output hpt_pkg::sums_t               sums
);
    import hpt_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [NUM_ROWS][NUM_COLS];
    logic signed [PROD_W-1:0] prod_next [NUM_ROWS][NUM_COLS];
    logic signed [SUM_W-1:0]  pair_reg [NUM_ROWS][2];
    logic signed [SUM_W-1:0]  pair_next [NUM_ROWS][2];
    sums_t                    sum_reg;
    sums_t                    sum_next;
    logic [2:0]               v_reg;
    logic signed [COORD_W:0]  ops [NUM_COLS];

    // The fourth column multiplies the constant 1.0 in Q16.16.
    assign ops[0] = {x_in[COORD_W-1], x_in};
    assign ops[1] = {y_in[COORD_W-1], y_in};
    assign ops[2] = {z_in[COORD_W-1], z_in};
    assign ops[3] = (COORD_W+1)'(33'sd65536);

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                prod_next[r][c] = $signed(rows[r][COEF_W*c +: COEF_W]) * ops[c];
            end
            pair_next[r][0] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1]);
            pair_next[r][1] = SUM_W'(prod_reg[r][2]) + SUM_W'(prod_reg[r][3]);
            sum_next[r]     = pair_reg[r][0] + pair_reg[r][1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            pair_reg <= pair_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    assign out_valid = v_reg[2];
    assign sums      = sum_reg;

endmodule

FILE: sv/hpt_div.sv
// Case classification, unity-w rounding and a one-bit-per-stage restoring divider.
// Depends on hpt_pkg.
module hpt_div
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  hpt_pkg::sums_t  sums,
    output logic            out_valid,
    output hpt_pkg::quos_t  quos,
    output hpt_pkg::side_t  side
);
    import hpt_pkg::*;

    logic [MAG_W-1:0] r_reg  [DIV_STEPS+1][NUM_LANES];
    logic [MAG_W-1:0] r_next [DIV_STEPS+1][NUM_LANES];
    logic [QUO_W-1:0] sh_reg  [DIV_STEPS+1][NUM_LANES];
    logic [QUO_W-1:0] sh_next [DIV_STEPS+1][NUM_LANES];
    logic [MAG_W-1:0] dm_reg  [DIV_STEPS+1];
    logic [MAG_W-1:0] dm_next [DIV_STEPS+1];
    side_t            side_reg  [DIV_STEPS+1];
    side_t            side_next [DIV_STEPS+1];
    logic [DIV_STEPS:0] v_reg;

    always_comb
    begin
        logic signed [SUM_W-1:0] d;
        logic signed [SUM_W-1:0] n;
        logic [MAG_W-1:0]        dmag;
        logic [MAG_W-1:0]        nmag;
        logic [MAG_W:0]          rnd;
        logic [MAG_W:0]          t;
        logic                    ge;

        // Entry stage: magnitudes, signs, special cases, first remainder.
        d    = $signed(sums[NUM_LANES]);
        dmag = MAG_W'(d[SUM_W-1] ? -d : d);
        dm_next[0] = dmag;
        side_next[0].one     = (d == Q28_ONE);
        side_next[0].zero    = (d == '0);
        side_next[0].one_sat = 1'b0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            n    = $signed(sums[l]);
            nmag = MAG_W'(n[SUM_W-1] ? -n : n);
            side_next[0].neg[l] = n[SUM_W-1] ^ d[SUM_W-1];
            side_next[0].ovf[l] = {16'b0, nmag} >= {dmag, 16'b0};
            r_next[0][l]  = MAG_W'(nmag >> 16);
            sh_next[0][l] = {nmag[15:0], 17'b0};
            rnd = ({1'b0, nmag} + (MAG_W+1)'(2048)) >> 12;
            if (!n[SUM_W-1])
            begin
                if (rnd > (MAG_W+1)'(POS_LIMIT))
                begin
                    side_next[0].one_res[l] = OUT_MAX;
                    side_next[0].one_sat    = 1'b1;
                end
                else
                begin
                    side_next[0].one_res[l] = rnd[COORD_W-1:0];
                end
            end
            else
            begin
                if (rnd > (MAG_W+1)'(NEG_LIMIT))
                begin
                    side_next[0].one_res[l] = OUT_MIN;
                    side_next[0].one_sat    = 1'b1;
                end
                else
                begin
                    side_next[0].one_res[l] = -rnd[COORD_W-1:0];
                end
            end
        end

        // Each later stage brings in one numerator bit and yields one quotient bit.
        for (int s = 1; s <= DIV_STEPS; s++)
        begin
            dm_next[s]   = dm_reg[s-1];
            side_next[s] = side_reg[s-1];
            for (int l = 0; l < NUM_LANES; l++)
            begin
                t  = {r_reg[s-1][l], sh_reg[s-1][l][QUO_W-1]};
                ge = t >= {1'b0, dm_reg[s-1]};
                r_next[s][l]  = ge ? MAG_W'(t - {1'b0, dm_reg[s-1]}) : MAG_W'(t);
                sh_next[s][l] = {sh_reg[s-1][l][QUO_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= r_next;
            sh_reg   <= sh_next;
            dm_reg   <= dm_next;
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DIV_STEPS-1:0], in_valid};
        end
    end

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            quos[l] = sh_reg[DIV_STEPS][l];
        end
    end

    assign out_valid = v_reg[DIV_STEPS];
    assign side      = side_reg[DIV_STEPS];

endmodule

FILE: sv/hpt_post.sv
// Final stage: quotient rounding, sign, saturation and result selection.
// Depends on hpt_pkg.
module hpt_post
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  hpt_pkg::quos_t       quos,
    input  hpt_pkg::side_t       side,
    output logic                 out_valid,
    output hpt_pkg::coords_t     coords,
    output logic                 w_zero,
    output logic                 saturated
);
    import hpt_pkg::*;

    coords_t coords_reg;
    coords_t coords_next;
    logic    w_zero_reg;
    logic    w_zero_next;
    logic    sat_reg;
    logic    sat_next;
    logic    v_reg;

    always_comb
    begin
        logic [QUO_W:0]   qsum;
        logic [QUO_W-1:0] qr;
        coords_t          div_res;
        logic             div_sat;

        div_sat = 1'b0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            // One extra bit so that an all-ones quotient rounds up instead of wrapping.
            qsum = {1'b0, quos[l]} + (QUO_W+1)'(1);
            qr   = qsum[QUO_W:1];
            if (side.ovf[l])
            begin
                div_res[l] = side.neg[l] ? OUT_MIN : OUT_MAX;
                div_sat    = 1'b1;
            end
            else if (!side.neg[l])
            begin
                if (qr > POS_LIMIT)
                begin
                    div_res[l] = OUT_MAX;
                    div_sat    = 1'b1;
                end
                else
                begin
                    div_res[l] = qr[COORD_W-1:0];
                end
            end
            else
            begin
                if (qr > NEG_LIMIT)
                begin
                    div_res[l] = OUT_MIN;
                    div_sat    = 1'b1;
                end
                else
                begin
                    div_res[l] = -qr[COORD_W-1:0];
                end
            end
        end

        if (side.one)
        begin
            coords_next = side.one_res;
            sat_next    = side.one_sat;
            w_zero_next = 1'b0;
        end
        else if (side.zero)
        begin
            coords_next = '0;
            sat_next    = 1'b0;
            w_zero_next = 1'b1;
        end
        else
        begin
            coords_next = div_res;
            sat_next    = div_sat;
            w_zero_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coords_reg <= coords_next;
            w_zero_reg <= w_zero_next;
            sat_reg    <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    assign out_valid = v_reg;
    assign coords    = coords_reg;
    assign w_zero    = w_zero_reg;
    assign saturated = sat_reg;

endmodule

FILE: sv/homogeneous_point_transform_top.sv
// Top level of the homogeneous point transform; instantiates hpt_regs, hpt_dot,
// hpt_div and hpt_post, and depends on hpt_pkg.

// Each accepted word carries one point (x, y, z) in signed Q16.16, taken as the
// homogeneous vector (x, y, z, 1) and multiplied by the 4x4 matrix of signed
// Q4.12 coefficients held in four 64-bit row registers (row x at byte 0, row y
// at 8, row z at 16, row w at 24; column 0 in the low bits). When w is exactly
// 1.0 the sums are rounded to Q16.16; when w is zero the coordinates are zero
// and w_zero is set; otherwise each sum is divided by w, rounded to nearest
// with ties away from zero. Out-of-range results clip and set saturated.
// The block takes one word per cycle unless the output stalls, and returns one
// word per point, in order. Each point passes through the matrix product, the
// case split, the restoring divider (one quotient bit per stage) and one output
// register. The whole pipeline advances together whenever the output register
// is empty or being taken, so a stall at the output holds every stage and drops
// nothing. Rows are meant to be written while idle.
module homogeneous_point_transform_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    // s_tdata fields from bit 0 up: x_in[31:0], y_in[31:0], z_in[31:0]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [95:0]                  s_tdata,
    // m_tdata fields from bit 0 up: x_out[31:0], y_out[31:0], z_out[31:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [95:0]                  m_tdata,
    // m_tuser fields from bit 0 up: w_zero, saturated
    output logic [1:0]                   m_tuser,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hpt_pkg::PADDR_W-1:0]  paddr,
    input  logic [hpt_pkg::ROW_W-1:0]    pwdata,
    output logic [hpt_pkg::ROW_W-1:0]    prdata,
    output logic                         pready
);
    import hpt_pkg::*;

    rows_t   rows;
    sums_t   sums;
    quos_t   quos;
    side_t   side;
    coords_t coords;
    logic    en;
    logic    dot_valid;
    logic    div_valid;
    logic    w_zero;
    logic    saturated;

    // Global advance: the output register is free or its word is leaving.
    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    hpt_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rows    (rows)
    );

    hpt_dot u_dot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .x_in      (s_tdata[31:0]),
        .y_in      (s_tdata[63:32]),
        .z_in      (s_tdata[95:64]),
        .rows      (rows),
        .out_valid (dot_valid),
        .sums      (sums)
    );

    hpt_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dot_valid),
        .sums      (sums),
        .out_valid (div_valid),
        .quos      (quos),
        .side      (side)
    );

    hpt_post u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .quos      (quos),
        .side      (side),
        .out_valid (m_tvalid),
        .coords    (coords),
        .w_zero    (w_zero),
        .saturated (saturated)
    );

    assign m_tdata = {coords[2], coords[1], coords[0]};
    assign m_tuser = {saturated, w_zero};

    // A zero w gives zero coordinates and never a saturation.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && w_zero |-> (m_tdata == '0) && !saturated)
        else $error("w_zero word with nonzero coordinates or saturation");

    // A saturated word holds at least one coordinate at a range bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && saturated |->
            coords[0] == OUT_MAX || coords[0] == OUT_MIN ||
            coords[1] == OUT_MAX || coords[1] == OUT_MIN ||
            coords[2] == OUT_MAX || coords[2] == OUT_MIN)
        else $error("saturated word without a clipped coordinate");

    // The input side is held off only while a finished word waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting output word");

endmodule

FILE: bench/tb_homogeneous_point_transform_top.sv
// Self-checking bench for homogeneous_point_transform_top: directed table, then random points.
// Depends on hpt_pkg and the block's RTL; reads no files.
`timescale 1ns / 100ps

module tb_homogeneous_point_transform_top;
    import hpt_pkg::*;

    // One transformed point as it leaves the block.
    typedef struct packed
    {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        wz;
        logic        sat;
    } point_res_t;

    // One row of the directed table; chk says whether res is typed in.
    typedef struct
    {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        chk;
        point_res_t  res;
    } dir_row_t;

    localparam int SETTLE = 60;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [95:0]        s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [95:0]        m_tdata;
    logic [1:0]         m_tuser;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [ROW_W-1:0]   pwdata;
    logic [ROW_W-1:0]   prdata;
    logic               pready;

    homogeneous_point_transform_top DUT
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // The bench's own copy of the four matrix rows.
    logic [ROW_W-1:0] matrix_rows [NUM_ROWS];

    point_res_t pending_points[$];
    int  n_errors;
    int  n_points_in;
    int  n_points_out;
    int  n_wzero;
    int  n_sat;
    int  n_divided;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  quiet_cycles;
    bit  timed_out;

    // Signed coefficient of one row and column, widened for the products.
    function automatic longint coef_of(logic [ROW_W-1:0] row, int col);
        logic signed [15:0] c;
        c = row[16*col +: 16];
        return longint'(c);
    endfunction

    function automatic longint row_sum(logic [ROW_W-1:0] row, longint x, longint y, longint z);
        return coef_of(row, 0) * x + coef_of(row, 1) * y + coef_of(row, 2) * z
             + coef_of(row, 3) * 65536;
    endfunction

    function automatic longint clip32(longint v, ref bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q.28 down to Q16.16, ties rounded away from zero.
    function automatic longint narrow_q28(longint v, ref bit sat);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + 2048) >>> 12;
        return clip32((v < 0) ? -r : r, sat);
    endfunction

    // Restoring division on magnitudes with 17 fraction bits, then rounding.
    function automatic longint divide_by_w(longint n, longint d, ref bit sat);
        bit neg;
        logic [63:0] nm;
        logic [63:0] dm;
        logic [63:0] q;
        logic [63:0] r;
        neg = (n < 0) != (d < 0);
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        q = nm / dm;
        r = nm % dm;
        if (q >= 64'h1_0000)
        begin
            sat = 1'b1;
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        end
        for (int i = 0; i < 17; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= dm)
            begin
                r = r - dm;
                q[0] = 1'b1;
            end
        end
        q = (q + 1) >> 1;
        return clip32(neg ? -longint'(q) : longint'(q), sat);
    endfunction

    function automatic point_res_t transform_point(logic [31:0] xi, logic [31:0] yi,
                                                   logic [31:0] zi);
        point_res_t res;
        longint x;
        longint y;
        longint z;
        longint s [4];
        longint q [3];
        bit sat;
        x = longint'(signed'(xi));
        y = longint'(signed'(yi));
        z = longint'(signed'(zi));
        for (int i = 0; i < 4; i++)
            s[i] = row_sum(matrix_rows[i], x, y, z);
        sat = 1'b0;
        res.wz = 1'b0;
        q = '{0, 0, 0};
        if (s[REG_ROW_W] == 64'sd268435456)
        begin
            for (int i = 0; i < 3; i++)
                q[i] = narrow_q28(s[i], sat);
        end
        else if (s[REG_ROW_W] == 0)
            res.wz = 1'b1;
        else
        begin
            for (int i = 0; i < 3; i++)
                q[i] = divide_by_w(s[i], s[REG_ROW_W], sat);
        end
        res.x = q[0][31:0];
        res.y = q[1][31:0];
        res.z = q[2][31:0];
        res.sat = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at point %0d: %s got %h expected %h", n_points_out, what, got, want);
        n_errors++;
    endtask

    // Register writes go through a setup phase and an access phase, launched on falling edges.
    task automatic write_row(reg_idx_t idx, logic [ROW_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(8 * int'(idx));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        matrix_rows[idx] = value;
    endtask

    task automatic load_matrix(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry,
                               logic [ROW_W-1:0] rz, logic [ROW_W-1:0] rw);
        write_row(REG_ROW_X, rx);
        write_row(REG_ROW_Y, ry);
        write_row(REG_ROW_Z, rz);
        write_row(REG_ROW_W, rw);
    endtask

    // Offers one point, with random idle cycles ahead of it, and holds it until taken.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_points.push_back(transform_point(x, y, z));
        n_points_in++;
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Random coordinate: mostly moderate values, sometimes any 32-bit pattern.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(2 * 65536 * 16)) - 65536 * 16);
            default: return 32'(signed'($urandom_range(2 * 65536 * 256)) - 65536 * 256);
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(3))
            0: return $urandom;
            default: return 16'(signed'($urandom_range(8192)) - 4096);
        endcase
    endfunction

    // A random matrix; the w row is either affine (w = 1.0) or a perspective row.
    function automatic void pick_matrix(output logic [ROW_W-1:0] r [NUM_ROWS]);
        for (int i = 0; i < 3; i++)
            r[i] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
        case ($urandom_range(3))
            0: r[3] = ROW_W_RESET;
            1: r[3] = {16'h1000, 16'(signed'($urandom_range(64)) - 32), 16'h0, 16'h0};
            default: r[3] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
        endcase
    endfunction

    // Receiver side: random stalls plus the forced long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Output checker, sampled at the rising edge.
    always @(posedge clk)
    begin
        point_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_points.size() == 0)
            begin
                $display("unexpected result word %h", m_tdata);
                n_errors++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (m_tdata[31:0] !== want.x)
                    report_mismatch("x_out", m_tdata[31:0], want.x);
                if (m_tdata[63:32] !== want.y)
                    report_mismatch("y_out", m_tdata[63:32], want.y);
                if (m_tdata[95:64] !== want.z)
                    report_mismatch("z_out", m_tdata[95:64], want.z);
                if (m_tuser[0] !== want.wz)
                    report_mismatch("w_zero", 32'(m_tuser[0]), 32'(want.wz));
                if (m_tuser[1] !== want.sat)
                    report_mismatch("saturated", 32'(m_tuser[1]), 32'(want.sat));
                n_wzero += want.wz;
                n_sat   += want.sat;
                n_divided += (!want.wz && (matrix_rows[REG_ROW_W] != ROW_W_RESET));
            end
            n_points_out++;
        end
    end

    // Watchdog: cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering points.
    task automatic hold_receiver(int cycles);
        recv_hold = 1'b1;
        repeat (cycles) @(posedge clk);
        recv_hold = 1'b0;
    endtask

    initial
    begin
        dir_row_t dir_table [$];
        logic [ROW_W-1:0] r [NUM_ROWS];
        point_res_t exp_res;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        recv_hold = 1'b0;
        n_errors = 0;
        n_points_in = 0;
        n_points_out = 0;
        n_wzero = 0;
        n_sat = 0;
        n_divided = 0;
        send_idle_pct = 15;
        recv_idle_pct = 52;
        matrix_rows[0] = ROW_X_RESET;
        matrix_rows[1] = ROW_Y_RESET;
        matrix_rows[2] = ROW_Z_RESET;
        matrix_rows[3] = ROW_W_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Identity after reset: the point comes back unchanged, including the extremes.
        dir_table.push_back('{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b1,
                              '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0, 1'b0}});
        dir_table.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1,
                              '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, 1'b0}});
        dir_table.push_back('{32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA, 1'b1,
                              '{32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA, 1'b0, 1'b0}});
        foreach (dir_table[i])
        begin
            send_point(dir_table[i].x, dir_table[i].y, dir_table[i].z);
            if (dir_table[i].chk)
                pending_points[$] = dir_table[i].res;
        end
        drain_pipeline();

        // Zero w row: every point gives w zero with zero coordinates.
        load_matrix(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_8000_8000_8000,
                    64'h7FFF_7FFF_7FFF_7FFF, 64'h0);
        dir_table.delete();
        dir_table.push_back('{32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                              '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0}});
        dir_table.push_back('{32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0}});
        foreach (dir_table[i])
        begin
            send_point(dir_table[i].x, dir_table[i].y, dir_table[i].z);
            pending_points[$] = dir_table[i].res;
        end
        drain_pipeline();

        // Extreme coefficients with w = 1: products overflow and clip.
        load_matrix(64'h0000_7FFF_7FFF_7FFF, 64'h0000_8000_8000_8000,
                    64'h7FFF_0000_0000_0000, ROW_W_RESET);
        dir_table.delete();
        dir_table.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                              '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0007_FFF0, 1'b0, 1'b1}});
        dir_table.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0});
        dir_table.push_back('{32'h0000_0001, 32'h0, 32'h0, 1'b0, '0});
        dir_table.push_back('{32'h0000_0003, 32'hFFFF_FFFD, 32'h0, 1'b0, '0});
        foreach (dir_table[i])
        begin
            send_point(dir_table[i].x, dir_table[i].y, dir_table[i].z);
            if (dir_table[i].chk)
                pending_points[$] = dir_table[i].res;
        end
        drain_pipeline();

        // Perspective rows: zero w, tiny w and w = 2.0.
        load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                    64'h0000_1000_0000_0000, 64'h0000_0001_0000_0000);
        dir_table.delete();
        dir_table.push_back('{32'h0001_0000, 32'h0, 32'h0, 1'b0, '0});
        dir_table.push_back('{32'h0, 32'h0001_0000, 32'h0, 1'b0, '0});
        dir_table.push_back('{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0, '0});
        dir_table.push_back('{32'h0, 32'h0000_0003, 32'h0000_0001, 1'b0, '0});
        foreach (dir_table[i])
            send_point(dir_table[i].x, dir_table[i].y, dir_table[i].z);
        drain_pipeline();
        load_matrix(64'hF000_0000_0000_1000, 64'hE000_0000_1000_0000,
                    64'h0000_F000_0000_0000, 64'h2000_0000_0000_0000);
        dir_table.delete();
        dir_table.push_back('{32'h0003_0000, 32'hFFFD_0000, 32'h0000_0001, 1'b0, '0});
        dir_table.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0003, 1'b0, '0});
        foreach (dir_table[i])
            send_point(dir_table[i].x, dir_table[i].y, dir_table[i].z);
        drain_pipeline();

        // Random part in three idling phases, a new matrix every 95 points.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 52 : 0;
            recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 15 : 0;
            for (int blk = 0; blk < 7; blk++)
            begin
                pick_matrix(r);
                load_matrix(r[0], r[1], r[2], r[3]);
                if (ph == 2 && blk == 0)
                begin
                    fork
                        hold_receiver(300);
                    join_none
                end
                for (int k = 0; k < 95; k++)
                    send_point(rand_coord(), rand_coord(), rand_coord());
                drain_pipeline();
            end
        end

        $display("points sent %0d, checked %0d: %0d with w zero, %0d saturated, %0d divided",
                 n_points_in, n_points_out, n_wzero, n_sat, n_divided);
        $display("matrix reloaded between phases under three idling mixes and a long stall");
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
